[sv/delay_line_pitch_shifter_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the delay line pitch shifter
// Shared property forms, each disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef DELAY_LINE_PITCH_SHIFTER_CORE_ASSERT_SVH
`define DELAY_LINE_PITCH_SHIFTER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DLPS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DLPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/dlps_pkg.sv]
// ----------------------------------------------------------------------------
// dlps_pkg
// Shared widths, codes, controller states and the command bundle.
// ----------------------------------------------------------------------------
package dlps_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RATIO_W  = 18;
    localparam int PHASE_W  = 26;   // Q10.16 delay phase
    localparam int PSUM_W   = 28;   // phase plus step, below three spans
    localparam int K_W      = 10;   // integer part of the phase
    localparam int FRAC_W   = 16;
    localparam int GAIN_W   = 17;   // Q16 crossfade gain, up to 1.0
    localparam int QUOT_W   = 18;   // raw phase / crossfade length
    localparam int TAP_W    = 33;   // Q16 interpolated tap
    localparam int MIX_W    = 49;   // Q32 crossfaded value
    localparam int ESUM_W   = 50;   // Q32 echo sum
    localparam int RECIP_W  = 27;
    localparam int PROD_W   = PHASE_W + RECIP_W;

    localparam logic [GAIN_W-1:0]  GAIN_ONE    = 17'h10000;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 18'h10000;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    typedef enum logic [0:0] {
        REG_PITCH_RATIO = 1'b0,
        REG_ECHO_ENABLE = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRAP,
        ST_RECIP,
        ST_TAP_A0,
        ST_TAP_A1,
        ST_TAP_B0,
        ST_TAP_B1,
        ST_DIFF,
        ST_MIX,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        TAP_A0,
        TAP_A1,
        TAP_B0,
        TAP_B1
    } tap_sel_t;

    typedef struct packed {
        logic     take;
        logic     ld_wrap;
        logic     ld_recip;
        tap_sel_t tap_sel;
        logic     ld_d0;
        logic     ld_gain;
        logic     ld_ta;
        logic     ld_tb;
        logic     ld_diff;
        logic     ld_mix;
        logic     ld_sum;
        logic     finish;
    } dp_cmd_t;

    // Truncate a Q32 value toward zero, then clamp to a 16-bit sample.
    function automatic logic signed [SAMPLE_W-1:0] trunc_sat(
        input logic signed [ESUM_W-1:0] v
    );
        logic signed [ESUM_W-1:0]    biased;
        logic signed [ESUM_W-33:0]   whole;
        logic signed [SAMPLE_W-1:0]  res;
        biased = v + {{(ESUM_W-32){1'b0}}, {32{v[ESUM_W-1]}}};
        whole  = biased[ESUM_W-1:32];
        if (whole > 18'sd32767) begin
            res = 16'sh7FFF;
        end else if (whole < -18'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = whole[SAMPLE_W-1:0];
        end
        return res;
    endfunction

endpackage

[sv/dlps_ram.sv]
// ----------------------------------------------------------------------------
// dlps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dlps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/dlps_ctrl.sv]
// ----------------------------------------------------------------------------
// dlps_ctrl
// Sequencer: walks one sample through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module dlps_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output dlps_pkg::dp_cmd_t cmd
);

    import dlps_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        out_free   = !m_valid_reg || m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP: begin
                cmd.ld_wrap = 1'b1;
                state_next  = ST_RECIP;
            end
            ST_RECIP: begin
                cmd.ld_recip = 1'b1;
                cmd.tap_sel  = TAP_A0;
                state_next   = ST_TAP_A0;
            end
            ST_TAP_A0: begin
                cmd.ld_d0   = 1'b1;
                cmd.ld_gain = 1'b1;
                cmd.tap_sel = TAP_A1;
                state_next  = ST_TAP_A1;
            end
            ST_TAP_A1: begin
                cmd.ld_ta   = 1'b1;
                cmd.tap_sel = TAP_B0;
                state_next  = ST_TAP_B0;
            end
            ST_TAP_B0: begin
                cmd.ld_d0   = 1'b1;
                cmd.tap_sel = TAP_B1;
                state_next  = ST_TAP_B1;
            end
            ST_TAP_B1: begin
                cmd.ld_tb  = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.ld_diff = 1'b1;
                state_next  = ST_MIX;
            end
            ST_MIX: begin
                cmd.ld_mix = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.ld_sum = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

[sv/dlps_datapath.sv]
// ----------------------------------------------------------------------------
// dlps_datapath
// Delay lines, phase accumulator, taps, crossfade and echo arithmetic.
// ----------------------------------------------------------------------------
module dlps_datapath #(
    parameter int DRY_DEPTH  = 2048,
    parameter int ECHO_DEPTH = 8192,
    parameter int ECHO_DELAY = 4801,
    parameter int WINDOW_LEN = 1000
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  dlps_pkg::dp_cmd_t                     cmd,
    input  logic signed [dlps_pkg::SAMPLE_W-1:0]  in_sample,
    input  logic [dlps_pkg::RATIO_W-1:0]          pitch_ratio,
    input  logic                                  echo_enable,
    output logic signed [dlps_pkg::SAMPLE_W-1:0]  out_sample
);

    import dlps_pkg::*;

    localparam int DRY_AW  = $clog2(DRY_DEPTH);
    localparam int ECHO_AW = $clog2(ECHO_DEPTH);
    localparam int IDX_W   = (DRY_AW > ECHO_AW) ? DRY_AW : ECHO_AW;

    localparam int XF_LEN  = WINDOW_LEN / 2;
    localparam int XF_LOG  = $clog2(XF_LEN);
    localparam int RSHIFT  = PHASE_W + XF_LOG;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RSHIFT) + 64'(XF_LEN) - 64'd1) / 64'(XF_LEN);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    localparam logic [PSUM_W-1:0] SPAN      = PSUM_W'(WINDOW_LEN * 65536);
    localparam logic [PSUM_W-1:0] SPAN2     = PSUM_W'(2 * WINDOW_LEN * 65536);
    localparam logic [PSUM_W-1:0] STEP_BASE = PSUM_W'((WINDOW_LEN + 1) * 65536);

    localparam int DIST_W   = $clog2(2 * WINDOW_LEN + 1);
    localparam int FILL_MAX = (ECHO_DELAY > 2 * WINDOW_LEN) ? ECHO_DELAY : 2 * WINDOW_LEN;
    localparam int FILL_W   = $clog2(FILL_MAX + 1);
    localparam int CMP_W    = (FILL_W > DIST_W) ? FILL_W : DIST_W;

    // control state
    logic [IDX_W-1:0]          widx_reg;
    logic [PHASE_W-1:0]        phase_reg;
    logic [FILL_W-1:0]         fill_reg;

    // payload
    logic [PSUM_W-1:0]         psum_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [GAIN_W-1:0]         gain_reg;
    logic signed [SAMPLE_W-1:0] old_echo_reg;
    logic signed [SAMPLE_W-1:0] d0_reg;
    logic                      tap_ok_reg;
    logic signed [TAP_W-1:0]   ta_reg;
    logic signed [TAP_W-1:0]   tb_reg;
    logic signed [TAP_W:0]     diff_reg;
    logic signed [MIX_W-1:0]   mix_reg;
    logic signed [ESUM_W-1:0]  esum_reg;
    logic signed [SAMPLE_W-1:0] dry_res_reg;
    logic signed [SAMPLE_W-1:0] out_reg;

    logic [PHASE_W-1:0]        phase_wrapped;
    logic [PSUM_W-1:0]         psum_less1;
    logic [PSUM_W-1:0]         psum_less2;
    logic [K_W-1:0]            tap_k;
    logic [FRAC_W-1:0]         tap_f;
    logic [DIST_W-1:0]         tap_off;
    logic [DIST_W-1:0]         tap_dist;
    logic [DRY_AW-1:0]         dry_raddr;
    logic [SAMPLE_W-1:0]       dry_rdata;
    logic [SAMPLE_W-1:0]       echo_rdata;
    logic [ECHO_AW-1:0]        echo_raddr;
    logic signed [SAMPLE_W-1:0] tap_sample;
    logic signed [SAMPLE_W:0]  tap_diff;
    logic signed [FRAC_W:0]    frac_s;
    logic signed [TAP_W:0]     tap_prod;
    logic signed [TAP_W:0]     tap_sum;
    logic [QUOT_W-1:0]         quot;
    logic signed [GAIN_W:0]    gain_s;
    logic signed [TAP_W+GAIN_W+1:0] mix_prod;
    logic signed [TAP_W+GAIN_W+1:0] mix_sum;
    logic signed [SAMPLE_W-1:0] echo_val;

    assign tap_k = phase_reg[PHASE_W-1:FRAC_W];
    assign tap_f = phase_reg[FRAC_W-1:0];

    // Phase wrap: the sum lies below three spans, so test both in parallel.
    assign psum_less1 = psum_reg - SPAN;
    assign psum_less2 = psum_reg - SPAN2;

    always_comb begin
        priority if (psum_reg >= SPAN2) begin
            phase_wrapped = psum_less2[PHASE_W-1:0];
        end else if (psum_reg >= SPAN) begin
            phase_wrapped = psum_less1[PHASE_W-1:0];
        end else begin
            phase_wrapped = psum_reg[PHASE_W-1:0];
        end
    end

    // Tap address: back distance from the newest sample.
    always_comb begin
        unique case (cmd.tap_sel)
            TAP_A0:  tap_off = '0;
            TAP_A1:  tap_off = DIST_W'(1);
            TAP_B0:  tap_off = DIST_W'(WINDOW_LEN);
            TAP_B1:  tap_off = DIST_W'(WINDOW_LEN + 1);
            default: tap_off = '0;
        endcase
    end

    assign tap_dist  = DIST_W'(tap_k) + tap_off;
    assign dry_raddr = widx_reg[DRY_AW-1:0] - DRY_AW'(tap_dist);
    assign echo_raddr = widx_reg[ECHO_AW-1:0] - ECHO_AW'(ECHO_DELAY);

    dlps_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DRY_DEPTH)
    ) u_dry_ram (
        .aclk  (aclk),
        .we    (cmd.take),
        .waddr (widx_reg[DRY_AW-1:0]),
        .wdata (in_sample),
        .raddr (dry_raddr),
        .rdata (dry_rdata)
    );

    dlps_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (ECHO_DEPTH)
    ) u_echo_ram (
        .aclk  (aclk),
        .we    (cmd.finish),
        .waddr (widx_reg[ECHO_AW-1:0]),
        .wdata (echo_val),
        .raddr (echo_raddr),
        .rdata (echo_rdata)
    );

    // Entries never written since reset read as zero.
    assign tap_sample = tap_ok_reg ? $signed(dry_rdata) : '0;

    // tap = d0 * (1 - f) + d1 * f, written as d0 + (d1 - d0) * f
    assign tap_diff = {tap_sample[SAMPLE_W-1], tap_sample} - {d0_reg[SAMPLE_W-1], d0_reg};
    assign frac_s   = {1'b0, tap_f};
    assign tap_prod = tap_diff * frac_s;
    assign tap_sum  = {{2{d0_reg[SAMPLE_W-1]}}, d0_reg, {FRAC_W{1'b0}}} + tap_prod;

    assign quot   = prod_reg[RSHIFT +: QUOT_W];
    assign gain_s = {1'b0, gain_reg};

    // mix = ta * g + tb * (1 - g), written as tb + (ta - tb) * g
    assign mix_prod = diff_reg * gain_s;
    assign mix_sum  = {{3{tb_reg[TAP_W-1]}}, tb_reg, {FRAC_W{1'b0}}}
                      + mix_prod;

    assign echo_val = trunc_sat(esum_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            widx_reg  <= '0;
            phase_reg <= '0;
            fill_reg  <= '0;
        end else begin
            if (cmd.ld_wrap) begin
                phase_reg <= phase_wrapped;
            end
            if (cmd.finish) begin
                widx_reg <= widx_reg + IDX_W'(1);
                if (fill_reg != FILL_W'(FILL_MAX)) begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        tap_ok_reg <= CMP_W'(tap_dist) <= CMP_W'(fill_reg);
        if (cmd.take) begin
            psum_reg <= PSUM_W'(phase_reg) + STEP_BASE - PSUM_W'(pitch_ratio);
        end
        if (cmd.ld_wrap) begin
            old_echo_reg <= (CMP_W'(ECHO_DELAY) <= CMP_W'(fill_reg))
                            ? $signed(echo_rdata) : '0;
        end
        if (cmd.ld_recip) begin
            prod_reg <= PROD_W'(phase_reg) * PROD_W'(RECIP);
        end
        if (cmd.ld_gain) begin
            gain_reg <= (quot > QUOT_W'(GAIN_ONE)) ? GAIN_ONE : quot[GAIN_W-1:0];
        end
        if (cmd.ld_d0) begin
            d0_reg <= tap_sample;
        end
        if (cmd.ld_ta) begin
            ta_reg <= tap_sum[TAP_W-1:0];
        end
        if (cmd.ld_tb) begin
            tb_reg <= tap_sum[TAP_W-1:0];
        end
        if (cmd.ld_diff) begin
            diff_reg <= {ta_reg[TAP_W-1], ta_reg} - {tb_reg[TAP_W-1], tb_reg};
        end
        if (cmd.ld_mix) begin
            mix_reg <= mix_sum[MIX_W-1:0];
        end
        if (cmd.ld_sum) begin
            esum_reg    <= {mix_reg[MIX_W-1], mix_reg}
                           + {{3{old_echo_reg[SAMPLE_W-1]}}, old_echo_reg, {31{1'b0}}};
            dry_res_reg <= trunc_sat({mix_reg[MIX_W-1], mix_reg});
        end
        if (cmd.finish) begin
            out_reg <= echo_enable ? echo_val : dry_res_reg;
        end
    end

    assign out_sample = out_reg;

endmodule

[sv/delay_line_pitch_shifter_core.sv]
// ----------------------------------------------------------------------------
// delay_line_pitch_shifter_core
// Pitch shifter over a dry delay line with crossfaded taps and an echo line.
// ----------------------------------------------------------------------------
// Each accepted beat carries one signed 16-bit sample and yields exactly one
// shifted sample. s_ready stays low from acceptance until the edge where the
// result beat is presented, so no new sample is taken while the last one is
// in flight or while its result waits for a free output register; the four
// interpolation reads queue on the single read port of the dry line,
// followed by the reciprocal-multiply crossfade and echo arithmetic. The
// output register holds a result while the next sample is taken. Delay lines
// start as all zeros without a clearing pass: a fill count marks which
// entries have been written since reset, and unwritten entries read as zero,
// so the core is ready straight out of reset.
// Program pitch_ratio_q16 (offset 0) and echo_enable (offset 4) over the
// APB-style port only while the core is idle.
// ----------------------------------------------------------------------------
module delay_line_pitch_shifter_core #(
    parameter int DRY_DEPTH  = 2048,
    parameter int ECHO_DEPTH = 8192,
    parameter int ECHO_DELAY = 4801,
    parameter int WINDOW_LEN = 1000
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // sample in
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [dlps_pkg::SAMPLE_W-1:0]  s_in_sample,
    // sample out
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [dlps_pkg::SAMPLE_W-1:0]  m_out_sample,
    // register port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [dlps_pkg::ADDR_W-1:0]           paddr,
    input  logic [dlps_pkg::DATA_W-1:0]           pwdata,
    output logic [dlps_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready
);

    import dlps_pkg::*;

    logic [RATIO_W-1:0] ratio_reg;
    logic               echo_en_reg;
    logic               cfg_write;
    reg_idx_t           reg_idx;
    dp_cmd_t            cmd;

    // Register index is the word offset; byte lanes below it are ignored.
    assign reg_idx   = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg   <= RATIO_RESET;
            echo_en_reg <= 1'b0;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_PITCH_RATIO: ratio_reg   <= pwdata[RATIO_W-1:0];
                REG_ECHO_ENABLE: echo_en_reg <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Readback of the selected register, zero-extended to the bus.
    always_comb begin
        unique case (reg_idx)
            REG_PITCH_RATIO: prdata = DATA_W'(ratio_reg);
            REG_ECHO_ENABLE: prdata = DATA_W'(echo_en_reg);
            default:         prdata = '0;
        endcase
    end

    // Sequencer: one sample at a time, drives the datapath load strobes.
    dlps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Delay lines, phase, taps, crossfade, echo and the output register.
    dlps_datapath #(
        .DRY_DEPTH  (DRY_DEPTH),
        .ECHO_DEPTH (ECHO_DEPTH),
        .ECHO_DELAY (ECHO_DELAY),
        .WINDOW_LEN (WINDOW_LEN)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_sample   (s_in_sample),
        .pitch_ratio (ratio_reg),
        .echo_enable (echo_en_reg),
        .out_sample  (m_out_sample)
    );

endmodule

[sv/dlps_checker.sv]
// ----------------------------------------------------------------------------
// dlps_checker
// Port-level checks on the pitch shifter core, bound to the top level.
// ----------------------------------------------------------------------------
`include "delay_line_pitch_shifter_core_assert.svh"

module dlps_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic signed [dlps_pkg::SAMPLE_W-1:0]  s_in_sample,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [dlps_pkg::SAMPLE_W-1:0]  m_out_sample,
    input logic                                  psel,
    input logic                                  penable,
    input logic                                  pwrite,
    input logic [dlps_pkg::ADDR_W-1:0]           paddr,
    input logic [dlps_pkg::DATA_W-1:0]           pwdata,
    input logic [dlps_pkg::DATA_W-1:0]           prdata,
    input logic                                  pready
);

    import dlps_pkg::*;

    // A stalled result beat holds its sample.
    `DLPS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_out_sample), "output beat changed while stalled")

    // After a sample is taken the core is busy and no result appears at once.
    `DLPS_ASSERT_NEXT(a_busy_after_take, aclk, aresetn, s_valid && s_ready,
        !s_ready && !$rose(m_valid), "core ready or result too early after take")

    // Ratio readback returns the last written value.
    `DLPS_ASSERT_NEXT(a_ratio_readback, aclk, aresetn,
        psel && penable && pwrite && pready && paddr[2] == REG_PITCH_RATIO,
        !(psel && !pwrite && paddr[2] == REG_PITCH_RATIO)
            || prdata[RATIO_W-1:0] == $past(pwdata[RATIO_W-1:0]),
        "pitch ratio readback mismatch")

    // Echo enable readback returns the last written value.
    `DLPS_ASSERT_NEXT(a_echo_readback, aclk, aresetn,
        psel && penable && pwrite && pready && paddr[2] == REG_ECHO_ENABLE,
        !(psel && !pwrite && paddr[2] == REG_ECHO_ENABLE)
            || prdata[0] == $past(pwdata[0]),
        "echo enable readback mismatch")

endmodule

bind delay_line_pitch_shifter_core dlps_checker u_dlps_checker (.*);
